// ===== sv/dsfl_pkg.sv =====
// shared types and field widths for the decode slot free list
`default_nettype none
package dsfl_pkg;

	localparam int SLOT_W  = 5;
	localparam int MASK_W  = 32;
	localparam int COUNT_W = 6;

	// command codes
	localparam logic CMD_ALLOCATE = 1'b0;
	localparam logic CMD_RELEASE  = 1'b1;

	typedef struct packed {
		logic              command;
		logic [MASK_W-1:0] release_mask;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               empty_error;
		logic [COUNT_W-1:0] free_count;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/decode_slot_free_list_core.sv =====
// decode slot free list: fifo of free picture slots with a free bitmap
//
// Command channel: a beat is taken when start is high and busy is low.
// cmd.command selects allocate (pop the oldest free slot) or release
// (queue every slot set in cmd.release_mask that is below the slot count
// and not already free, in ascending order).
// Result channel: one beat per command, shown for one cycle with done high.
// The receiver has no back pressure and must take it in that cycle.
// Allocate issues one ram read of the queue head and gives its beat from
// ST_ALLOC; allocate on an empty list reports empty_error straight from
// idle; release walks the mask one bit per cycle through the single
// ram write port. busy stays high until the result beat.
// Configuration: cfg_we with cfg_wdata writes the slot count (saturated to
// MAX_SLOTS) and refills the list with 0 to count-1; write only while idle.
// Reset: slot count min(32, MAX_SLOTS), list full in order, all slots free.
// The refill needs no sweep: the per-entry written flags clear together.
`default_nettype none
module decode_slot_free_list_core
	import dsfl_pkg::*;
#(
	parameter int MAX_SLOTS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire cmd_t               cmd,
	output logic                    busy,
	output logic                    done,
	output result_t                 result,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata
);

	localparam int PW      = $clog2(MAX_SLOTS);
	localparam int CW      = $clog2(MAX_SLOTS + 1);
	localparam int WALK    = (MAX_SLOTS < MASK_W) ? MAX_SLOTS : MASK_W;
	localparam int IW      = $clog2(WALK);
	localparam int RST_CNT = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
	localparam int RST_LIM = (RST_CNT < WALK) ? RST_CNT : WALK;

	typedef enum logic [1:0] {ST_IDLE, ST_ALLOC, ST_WALK} state_t;

	state_t          state_q;
	logic [CW-1:0]   lim_q;
	logic [PW-1:0]   head_q;
	logic [PW-1:0]   tail_q;
	logic [CW-1:0]   queued_q;
	logic [MAX_SLOTS-1:0] bitmap_q;
	logic [WALK-1:0] mask_q;
	logic [IW-1:0]   walk_q;
	logic            done_q;
	result_t         result_q;

	logic [CW-1:0]   cfg_cnt;
	logic [CW-1:0]   cfg_lim;
	logic            accept;
	logic [PW-1:0]   head_next;
	logic [PW-1:0]   tail_next;
	logic [PW-1:0]   pop_slot;
	logic [PW-1:0]   walk_slot;
	logic            push;
	logic            walk_last;
	logic [CW-1:0]   queued_walk;
	logic            ram_rd_en;
	logic            ram_wr_en;
	logic [PW-1:0]   ram_rd_data;
	logic            ram_rd_written;

	// saturate the written count
	always_comb begin
		if ({1'b0, cfg_wdata} > (COUNT_W + 1)'(MAX_SLOTS)) begin
			cfg_cnt = CW'(MAX_SLOTS);
		end else begin
			cfg_cnt = CW'(cfg_wdata);
		end
		cfg_lim = (cfg_cnt > CW'(WALK)) ? CW'(WALK) : cfg_cnt;
	end

	// pointer wrap and per-step decisions
	always_comb begin
		accept      = start && !busy;
		head_next   = (head_q == PW'(MAX_SLOTS - 1)) ? '0 : head_q + PW'(1);
		tail_next   = (tail_q == PW'(MAX_SLOTS - 1)) ? '0 : tail_q + PW'(1);
		pop_slot    = ram_rd_written ? ram_rd_data : head_q;
		walk_slot   = PW'(walk_q);
		push        = (state_q == ST_WALK) && mask_q[walk_q] && !bitmap_q[walk_slot]
			&& (queued_q != CW'(MAX_SLOTS));
		walk_last   = (CW'(walk_q) == lim_q - CW'(1));
		queued_walk = push ? queued_q + CW'(1) : queued_q;
		ram_rd_en   = accept && (cmd.command == CMD_ALLOCATE) && (queued_q != '0);
		ram_wr_en   = push;
	end

	// control state, queue pointers, bitmap and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lim_q    <= CW'(RST_LIM);
			head_q   <= '0;
			tail_q   <= (RST_CNT == MAX_SLOTS) ? '0 : PW'(RST_CNT);
			queued_q <= CW'(RST_CNT);
			bitmap_q <= '1;
			mask_q   <= '0;
			walk_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						lim_q    <= cfg_lim;
						head_q   <= '0;
						tail_q   <= (cfg_cnt == CW'(MAX_SLOTS)) ? '0 : PW'(cfg_cnt);
						queued_q <= cfg_cnt;
						bitmap_q <= '1;
					end else if (accept) begin
						if (cmd.command == CMD_ALLOCATE) begin
							if (queued_q == '0) begin
								done_q               <= 1'b1;
								result_q.slot        <= '0;
								result_q.empty_error <= 1'b1;
								result_q.free_count  <= '0;
							end else begin
								state_q <= ST_ALLOC;
							end
						end else begin
							mask_q <= cmd.release_mask[WALK-1:0];
							walk_q <= '0;
							if (lim_q == '0) begin
								done_q               <= 1'b1;
								result_q.slot        <= '0;
								result_q.empty_error <= 1'b0;
								result_q.free_count  <= COUNT_W'(queued_q);
							end else begin
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_ALLOC: begin
					head_q               <= head_next;
					queued_q             <= queued_q - CW'(1);
					bitmap_q[pop_slot]   <= 1'b0;
					done_q               <= 1'b1;
					result_q.slot        <= SLOT_W'(pop_slot);
					result_q.empty_error <= 1'b0;
					result_q.free_count  <= COUNT_W'(queued_q - CW'(1));
					state_q              <= ST_IDLE;
				end
				ST_WALK: begin
					if (push) begin
						tail_q              <= tail_next;
						bitmap_q[walk_slot] <= 1'b1;
					end
					queued_q <= queued_walk;
					walk_q   <= walk_q + IW'(1);
					if (walk_last) begin
						done_q               <= 1'b1;
						result_q.slot        <= '0;
						result_q.empty_error <= 1'b0;
						result_q.free_count  <= COUNT_W'(queued_walk);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// queue storage
	dsfl_slot_ram #(
		.DEPTH (MAX_SLOTS),
		.AW    (PW)
	) u_ram (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_we && (state_q == ST_IDLE)),
		.wr_en      (ram_wr_en),
		.wr_addr    (tail_q),
		.wr_data    (walk_slot),
		.rd_en      (ram_rd_en),
		.rd_addr    (head_q),
		.rd_data    (ram_rd_data),
		.rd_written (ram_rd_written)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// an empty list error leaves nothing queued
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.empty_error |-> queued_q == '0)
		else $error("empty error reported with slots queued");

	// queue never holds more slots than exist
	a_queued_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queued_q <= CW'(MAX_SLOTS))
		else $error("queued count above slot capacity");

	// every result beat follows an accepted command or a busy cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result beat without a command");

	// an allocate pops exactly one slot
	a_pop_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |=> queued_q == $past(queued_q) - CW'(1))
		else $error("allocate did not pop one slot");

endmodule
`default_nettype wire

// ===== sv/dsfl_slot_ram.sv =====
// free queue storage: synchronous ram with per-entry written flags
`default_nettype none
module dsfl_slot_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clear,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [AW-1:0] rd_data,
	output logic               rd_written
);

	logic [AW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [AW-1:0] rd_data_q;
	logic rd_written_q;

	// data array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// written flags, the core reads an unwritten entry as its own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (clear) begin
				written_q <= '0;
			end else if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data    = rd_data_q;
	assign rd_written = rd_written_q;

endmodule
`default_nettype wire

// ===== verif/slot_list_checker.sv =====
// checker for the decode slot free list: predicts every result beat and compares it
module slot_list_checker
	import dsfl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire cmd_t               cmd,
	input  wire logic               busy,
	input  wire logic               done,
	input  wire result_t            result,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	output int                      fail_count,
	output int                      outstanding,
	output int                      checked,
	output int                      empty_hits
);

	localparam int LIST_DEPTH = 32;

	// shadow copy of the free list
	logic [SLOT_W-1:0]  slot_ring [LIST_DEPTH];
	logic [SLOT_W-1:0]  ring_head;
	logic [SLOT_W-1:0]  ring_tail;
	logic [COUNT_W-1:0] ring_fill;
	logic [MASK_W-1:0]  free_map;
	logic [COUNT_W-1:0] slot_limit;

	result_t            expected_beats [$];
	result_t            want_beat;

	task automatic report_mismatch(input string msg);
		if (fail_count < 50)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// new slot count: saturate, then list holds 0 to count-1 and every slot is free
	function automatic void refill_list(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] n;
		n = (count > LIST_DEPTH) ? COUNT_W'(LIST_DEPTH) : count;
		slot_limit = n;
		for (int i = 0; i < LIST_DEPTH; i++)
			slot_ring[i] = (i < n) ? SLOT_W'(i) : '0;
		ring_head = '0;
		ring_tail = SLOT_W'(n);
		ring_fill = n;
		free_map = '1;
	endfunction

	// apply one command to the shadow list and return the beat it should give
	function automatic result_t predict_result(input cmd_t c);
		result_t r;
		r = '0;
		if (c.command == CMD_ALLOCATE) begin
			if (ring_fill == 0) begin
				// empty list: flag it and leave everything alone
				r.empty_error = 1'b1;
			end else begin
				r.slot = slot_ring[ring_head];
				ring_head = ring_head + 1'b1;
				ring_fill = ring_fill - 1'b1;
				free_map[r.slot] = 1'b0;
			end
		end else begin
			// ascending walk; slots above the count or already free are skipped
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (i < slot_limit && c.release_mask[i] && !free_map[i]
						&& ring_fill < LIST_DEPTH) begin
					slot_ring[ring_tail] = SLOT_W'(i);
					ring_tail = ring_tail + 1'b1;
					ring_fill = ring_fill + 1'b1;
					free_map[i] = 1'b1;
				end
			end
		end
		r.free_count = ring_fill;
		return r;
	endfunction

	// result beats are retired before a new command is predicted on the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_list(COUNT_W'(LIST_DEPTH));
			expected_beats.delete();
		end else begin
			if (done) begin
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat, slot %0d free_count %0d",
						result.slot, result.free_count));
				end else begin
					want_beat = expected_beats.pop_front();
					checked++;
					if (result.slot !== want_beat.slot)
						report_mismatch($sformatf("slot got %0d want %0d",
							result.slot, want_beat.slot));
					if (result.empty_error !== want_beat.empty_error)
						report_mismatch($sformatf("empty_error got %b want %b",
							result.empty_error, want_beat.empty_error));
					if (result.free_count !== want_beat.free_count)
						report_mismatch($sformatf("free_count got %0d want %0d",
							result.free_count, want_beat.free_count));
				end
			end
			if (cfg_we)
				refill_list(cfg_wdata);
			if (start && !busy) begin
				want_beat = predict_result(cmd);
				if (want_beat.empty_error)
					empty_hits++;
				expected_beats.push_back(want_beat);
			end
		end
		outstanding = expected_beats.size();
	end

endmodule

// ===== verif/tb_decode_slot_free_list_core.sv =====
// testbench top for the decode slot free list: stimulus, slot-count phases and verdict
module tb_decode_slot_free_list_core;
	import dsfl_pkg::*;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	cmd_t               cmd       = '0;
	logic               cfg_we    = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               busy;
	logic               done;
	result_t            result;

	int fail_count;
	int outstanding;
	int checked;
	int empty_hits;

	int idle_pct;
	int n_alloc;
	int n_release;
	int n_cfg;

	decode_slot_free_list_core #(
		.MAX_SLOTS(32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	slot_list_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.outstanding(outstanding),
		.checked    (checked),
		.empty_hits (empty_hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic cmd_t beat_of(input logic op, input logic [MASK_W-1:0] mask);
		cmd_t c;
		c.command = op;
		c.release_mask = mask;
		return c;
	endfunction

	// mix of mask shapes: empty, full, one slot, sparse, random
	function automatic cmd_t random_cmd(input int alloc_pct);
		logic [MASK_W-1:0] mask;
		case ($urandom_range(9))
			0: mask = '0;
			1: mask = '1;
			2, 3: mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
			4, 5: mask = $urandom & $urandom;
			default: mask = $urandom;
		endcase
		if ($urandom_range(99) < alloc_pct)
			return beat_of(CMD_ALLOCATE, mask);
		return beat_of(CMD_RELEASE, mask);
	endfunction

	// slot counts with the extremes and saturating values well represented
	function automatic logic [COUNT_W-1:0] next_slot_count();
		case ($urandom_range(9))
			0: return '0;
			1: return COUNT_W'(1);
			2: return COUNT_W'(32);
			3: return COUNT_W'($urandom_range(33, 63));
			default: return COUNT_W'($urandom_range(2, 31));
		endcase
	endfunction

	// one command beat, preceded by a random gap with noise on the bus
	task automatic send_beat(input cmd_t c);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= {1'($urandom_range(1)), $urandom};
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		if (c.command == CMD_ALLOCATE)
			n_alloc++;
		else
			n_release++;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	// hold off until every expected beat is back and the block is idle
	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0 || busy);
		@(posedge clk);
	endtask

	task automatic write_slot_count(input logic [COUNT_W-1:0] value);
		drain_results();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	// run limit
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int seg_len;
		int pause_at;
		int alloc_pct;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset count of 32: pops in order, re-release, already free, empty and full masks
		send_beat(beat_of(CMD_ALLOCATE, '0));
		send_beat(beat_of(CMD_ALLOCATE, '1));
		send_beat(beat_of(CMD_RELEASE, 32'h0000_0002));
		send_beat(beat_of(CMD_RELEASE, '1));
		send_beat(beat_of(CMD_RELEASE, '0));
		send_beat(beat_of(CMD_RELEASE, 32'h8000_0001));
		send_beat(beat_of(CMD_ALLOCATE, '0));

		// one slot: empty list errors and mask bits above the count
		write_slot_count(COUNT_W'(1));
		send_beat(beat_of(CMD_ALLOCATE, '0));
		send_beat(beat_of(CMD_ALLOCATE, '1));
		send_beat(beat_of(CMD_RELEASE, 32'hFFFF_FFFE));
		send_beat(beat_of(CMD_ALLOCATE, '0));
		send_beat(beat_of(CMD_RELEASE, 32'h0000_0001));
		send_beat(beat_of(CMD_ALLOCATE, '0));

		// zero slots: nothing can ever be handed out
		write_slot_count('0);
		send_beat(beat_of(CMD_ALLOCATE, '0));
		send_beat(beat_of(CMD_RELEASE, '1));
		send_beat(beat_of(CMD_ALLOCATE, '1));

		// count above the maximum saturates
		write_slot_count('1);
		send_beat(beat_of(CMD_ALLOCATE, '0));
		send_beat(beat_of(CMD_ALLOCATE, '0));
		send_beat(beat_of(CMD_RELEASE, 32'h8000_0003));
		send_beat(beat_of(CMD_ALLOCATE, '0));

		// random segments, each under its own slot count, in three idle regimes
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 14 : (phase == 1) ? 75 : 0;
			for (int seg = 0; seg < 8; seg++) begin
				write_slot_count(next_slot_count());
				alloc_pct = $urandom_range(35, 80);
				seg_len = $urandom_range(40, 85);
				pause_at = $urandom_range(seg_len - 1);
				for (int k = 0; k < seg_len; k++) begin
					if (k == pause_at)
						drain_results();
					send_beat(random_cmd(alloc_pct));
				end
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("covered %0d allocate and %0d release beats over %0d slot-count writes",
			n_alloc, n_release, n_cfg);
		$display("%0d result beats compared, %0d of them empty-list errors",
			checked, empty_hits);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== decode_slot_free_list_core.f =====
sv/dsfl_pkg.sv
sv/dsfl_slot_ram.sv
sv/decode_slot_free_list_core.sv
verif/slot_list_checker.sv
verif/tb_decode_slot_free_list_core.sv
